@@ hdl/sgle_pkg.sv @@
// package: widths, register codes, gamma table and line code helper for the led encoder
`timescale 1ns / 1ps
package sgle_pkg;

  localparam int COORD_W = 6;
  localparam int LEVEL_W = 8;
  localparam int INDEX_W = 12;
  localparam int CODE_W = 32;
  localparam int DIM_W = 7;
  localparam int CFG_IDX_W = 1;

  localparam logic [DIM_W-1:0] MAX_DIM = 7'd64;
  localparam logic [DIM_W-1:0] GRID_WIDTH_RESET = 7'd19;
  localparam logic [DIM_W-1:0] GRID_HEIGHT_RESET = 7'd21;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'b1;

  localparam logic [3:0] CODE_ONE = 4'hE;
  localparam logic [3:0] CODE_ZERO = 4'h8;

  typedef logic [LEVEL_W-1:0] gamma_lut_t [256];

  // entry i counts k in 0..254 with 32 * i^11 > (2k+1)^5 * 255^6
  function automatic gamma_lut_t build_gamma_lut();
    gamma_lut_t lut;
    logic [127:0] lhs;
    logic [127:0] rhs;
    int unsigned k;
    bit done;
    k = 0;
    for (int i = 0; i < 256; i++) begin
      lhs = 128'd32;
      for (int n = 0; n < 11; n++) begin
        lhs = lhs * 128'(i);
      end
      done = 1'b0;
      for (int j = 0; j < 255; j++) begin
        if (!done && k < 255) begin
          rhs = 128'd1;
          for (int n = 0; n < 6; n++) begin
            rhs = rhs * 128'd255;
          end
          for (int n = 0; n < 5; n++) begin
            rhs = rhs * 128'(2 * k + 1);
          end
          if (lhs > rhs) begin
            k = k + 1;
          end else begin
            done = 1'b1;
          end
        end
      end
      lut[i] = LEVEL_W'(k);
    end
    return lut;
  endfunction

  localparam gamma_lut_t GAMMA_LUT = build_gamma_lut();

  // gamma-corrected level to eight nibble line codes, msb in top nibble
  function automatic logic [CODE_W-1:0] line_code(input logic [LEVEL_W-1:0] level);
    logic [LEVEL_W-1:0] c;
    logic [CODE_W-1:0] w;
    c = GAMMA_LUT[level];
    for (int b = 0; b < LEVEL_W; b++) begin
      w[b*4 +: 4] = c[b] ? CODE_ONE : CODE_ZERO;
    end
    return w;
  endfunction

endpackage

@@ hdl/sgle_pixel_if.sv @@
// interfaces: pixel input, encoded led output and configuration write channels
`timescale 1ns / 1ps
interface sgle_pixel_if import sgle_pkg::*; ();
  logic valid;
  logic ready;
  logic [COORD_W-1:0] column;
  logic [COORD_W-1:0] row;
  logic [LEVEL_W-1:0] red_level;
  logic [LEVEL_W-1:0] green_level;
  logic [LEVEL_W-1:0] blue_level;
  modport source (output valid, column, row, red_level, green_level, blue_level,
                  input ready);
  modport sink (input valid, column, row, red_level, green_level, blue_level,
                output ready);
endinterface

interface sgle_led_if import sgle_pkg::*; ();
  logic valid;
  logic ready;
  logic [INDEX_W-1:0] strip_index;
  logic [CODE_W-1:0] green_code;
  logic [CODE_W-1:0] red_code;
  logic [CODE_W-1:0] blue_code;
  modport source (output valid, strip_index, green_code, red_code, blue_code,
                  input ready);
  modport sink (input valid, strip_index, green_code, red_code, blue_code,
                output ready);
endinterface

interface sgle_cfg_if import sgle_pkg::*; ();
  logic valid;
  logic ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DIM_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ hdl/serpentine_gamma_led_encoder.sv @@
// top level: serpentine led pixel encoder with gamma table and line codes
// each pixel passes through the input register and then the result register before it shows valid on the led port
// throughput: one pixel per cycle while the led port accepts each result, input register and result register in a row
// pixels off the grid are dropped on the way into the result register and give no result
// reset (synchronous) clears both stage valids and sets the grid to 19 by 21
`timescale 1ns / 1ps
module serpentine_gamma_led_encoder import sgle_pkg::*; (
  input logic clk,
  input logic rst,
  sgle_pixel_if.sink pixel,
  sgle_led_if.source led,
  sgle_cfg_if.sink cfg
);

  logic [DIM_W-1:0] grid_width;
  logic [DIM_W-1:0] grid_height;

  logic in_valid;
  logic [COORD_W-1:0] in_column;
  logic [COORD_W-1:0] in_row;
  logic [LEVEL_W-1:0] in_red;
  logic [LEVEL_W-1:0] in_green;
  logic [LEVEL_W-1:0] in_blue;

  logic out_valid;
  logic [INDEX_W-1:0] out_index;
  logic [CODE_W-1:0] out_green;
  logic [CODE_W-1:0] out_red;
  logic [CODE_W-1:0] out_blue;

  logic advance;
  logic on_grid;
  logic [DIM_W-1:0] mirror_full;
  logic [COORD_W-1:0] mirror;
  logic [DIM_W-1:0] row_flip;
  logic [DIM_W-1:0] strip_row;
  logic [COORD_W+DIM_W-1:0] index_full;
  logic [DIM_W-1:0] cfg_value;

  assign cfg.ready = 1'b1;
  assign cfg_value = (cfg.data > MAX_DIM) ? MAX_DIM : cfg.data;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width <= GRID_WIDTH_RESET;
      grid_height <= GRID_HEIGHT_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_GRID_WIDTH: grid_width <= cfg_value;
        REG_GRID_HEIGHT: grid_height <= cfg_value;
        default: ;
      endcase
    end
  end

  assign advance = !out_valid || led.ready;
  assign pixel.ready = !in_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (pixel.ready) begin
      in_valid <= pixel.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pixel.ready && pixel.valid) begin
      in_column <= pixel.column;
      in_row <= pixel.row;
      in_red <= pixel.red_level;
      in_green <= pixel.green_level;
      in_blue <= pixel.blue_level;
    end
  end

  // serpentine mapping
  assign on_grid = ({1'b0, in_column} < grid_width) && ({1'b0, in_row} < grid_height);
  assign mirror_full = grid_width - 7'd1 - {1'b0, in_column};
  assign mirror = mirror_full[COORD_W-1:0];
  assign row_flip = grid_height - 7'd1 - {1'b0, in_row};
  assign strip_row = mirror[0] ? row_flip : {1'b0, in_row};
  assign index_full = {{DIM_W{1'b0}}, mirror} * {{COORD_W{1'b0}}, grid_height}
                    + {{COORD_W{1'b0}}, strip_row};

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid && on_grid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid && on_grid) begin
      out_index <= index_full[INDEX_W-1:0];
      out_green <= line_code(in_green);
      out_red <= line_code(in_red);
      out_blue <= line_code(in_blue);
    end
  end

  assign led.valid = out_valid;
  assign led.strip_index = out_index;
  assign led.green_code = out_green;
  assign led.red_code = out_red;
  assign led.blue_code = out_blue;

endmodule
